// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL. Both take a clock and an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define PFTE_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// When the first expression holds, the second must hold in the following cycle.
`define PFTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define PFTE_ASSERT(lbl, clk, rst_n, expr)
`define PFTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/pfte_pkg.sv =====
package pfte_pkg;

    localparam int MAX_FRAMES_DEF       = 250;
    localparam int MAX_PACKET_WORDS_DEF = 16 * 1024 * 1024;

    localparam int WORD_W = 32;
    localparam int PW_W   = 25;
    localparam int WI_W   = 25;
    localparam int FI_W   = 8;
    localparam int FSO_W  = 27;
    localparam int TRIG_W = 16;

    localparam logic [WORD_W-1:0] MAGIC_BE = 32'hCAFEBABE;
    localparam logic [WORD_W-1:0] MAGIC_LE = 32'hBEBAFECA;

    localparam logic [3:0] HDR_INNER_A = 4'hB;
    localparam logic [3:0] HDR_INNER_B = 4'h3;
    localparam logic [3:0] HDR_OUTER   = 4'hE;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_COUNT  = 2'd1,
        PH_TABLE  = 2'd2,
        PH_DATA   = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_FOUND   = 3'd0,
        ST_NONE    = 3'd1,
        ST_SIZE    = 3'd2,
        ST_MAGIC   = 3'd3,
        ST_COUNT   = 3'd4,
        ST_LENGTH  = 3'd5,
        ST_OVERRUN = 3'd6
    } t_status;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [PW_W-1:0]   packet_words;
        logic              last;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [TRIG_W-1:0] inner_trigger;
        logic              outer_seen;
        logic [TRIG_W-1:0] outer_trigger;
    } t_out_item;

    // Length table access from the parser.
    typedef struct packed {
        logic              we;
        logic [FI_W-1:0]   waddr;
        logic [WORD_W-1:0] wdata;
        logic [FI_W-1:0]   raddr_cur;
        logic [FI_W-1:0]   raddr_nxt;
    } t_tbl_req;

    typedef struct packed {
        t_phase          phase;
        logic            decided;
        logic [FI_W-1:0] frame_index;
        logic [FI_W-1:0] frame_count;
    } t_parse_stat;

endpackage

// ===== src/pfte_ram.sv =====
module pfte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    output logic [WIDTH-1:0] o_rdata_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Write-first: a read of the address being written returns the new data.
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr_a)) begin
            o_rdata_a <= i_wdata;
        end else begin
            o_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_we && (i_waddr == i_raddr_b)) begin
            o_rdata_b <= i_wdata;
        end else begin
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

// ===== src/pfte_in_stage.sv =====
module pfte_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  pfte_pkg::t_in_item i_item,
    output logic              o_valid,
    output pfte_pkg::t_in_item o_item,
    input  logic              i_pop
);
    import pfte_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_pop;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== src/pfte_out_stage.sv =====
module pfte_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  pfte_pkg::t_out_item i_res,
    output logic               o_free,
    output logic               o_valid,
    input  logic               i_ready,
    output pfte_pkg::t_out_item o_item
);
    import pfte_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_res;
        end
    end

endmodule

// ===== src/pfte_parser.sv =====
module pfte_parser #(
    parameter int MAX_FRAMES       = pfte_pkg::MAX_FRAMES_DEF,
    parameter int MAX_PACKET_WORDS = pfte_pkg::MAX_PACKET_WORDS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  pfte_pkg::t_in_item    i_item,
    input  logic [31:0]           i_cur_len,
    input  logic [31:0]           i_nxt_len,
    output pfte_pkg::t_tbl_req    o_tbl,
    output logic                  o_res_valid,
    output pfte_pkg::t_out_item   o_res,
    output pfte_pkg::t_parse_stat o_stat
);
    import pfte_pkg::*;

    function automatic logic length_bad(input logic [WORD_W-1:0] len);
        return (len == '0) || len[WORD_W-1];
    endfunction

    t_phase            r_phase, n_phase;
    logic              r_decided, n_decided;
    t_status           r_verdict, n_verdict;
    logic [WI_W-1:0]   r_word_index, n_word_index;
    logic [FI_W-1:0]   r_frame_count, n_frame_count;
    logic [FI_W-1:0]   r_frame_index, n_frame_index;
    logic [FSO_W-1:0]  r_fso, n_fso;
    logic [TRIG_W-1:0] r_inner, n_inner;
    logic              r_outer_seen, n_outer_seen;
    logic [TRIG_W-1:0] r_outer, n_outer;
    logic              r_first_bad, n_first_bad;

    logic [WI_W-1:0]  data_word;
    logic [FSO_W-1:0] frame_off;
    logic [FSO_W-1:0] room;
    logic [32:0]      frame_end;
    logic             overrun;
    logic [FSO_W-1:0] padded;
    logic [3:0]       hdr_type;

    // Byte offset of this word within the data area, and the data area size in words.
    assign data_word = r_word_index - WI_W'(2) - WI_W'(r_frame_count);
    assign frame_off = {data_word, 2'b00};
    assign room      = {2'b00, i_item.packet_words} - FSO_W'(2) - FSO_W'(r_frame_count);
    assign frame_end = {6'b0, r_fso} + {1'b0, i_cur_len};
    assign overrun   = room[FSO_W-1] || (frame_end > {4'b0, room, 2'b00});
    assign padded    = (i_cur_len[FSO_W-1:0] + FSO_W'(3)) & ~FSO_W'(3);
    assign hdr_type  = i_item.word[30:27];

    always_comb begin
        logic    consumed;
        logic    entered_data;
        logic    len_bad_last;
        t_status fin;

        n_phase       = r_phase;
        n_decided     = r_decided;
        n_verdict     = r_verdict;
        n_word_index  = r_word_index;
        n_frame_count = r_frame_count;
        n_frame_index = r_frame_index;
        n_fso         = r_fso;
        n_inner       = r_inner;
        n_outer_seen  = r_outer_seen;
        n_outer       = r_outer;
        n_first_bad   = r_first_bad;
        o_tbl         = '0;
        o_res_valid   = 1'b0;
        o_res         = '0;
        consumed      = 1'b0;
        entered_data  = 1'b0;
        len_bad_last  = 1'b0;
        fin           = ST_NONE;

        if (i_step) begin
            if (!r_decided) begin
                unique case (r_phase)
                    PH_HEADER: begin
                        if ((i_item.packet_words < PW_W'(2)) ||
                            (i_item.packet_words > PW_W'(MAX_PACKET_WORDS))) begin
                            n_decided = 1'b1;
                            n_verdict = ST_SIZE;
                        end else if ((i_item.word != MAGIC_BE) &&
                                     (i_item.word != MAGIC_LE)) begin
                            n_decided = 1'b1;
                            n_verdict = ST_MAGIC;
                        end else begin
                            n_phase = PH_COUNT;
                        end
                    end
                    PH_COUNT: begin
                        if ((i_item.word == '0) ||
                            (i_item.word > WORD_W'(MAX_FRAMES))) begin
                            n_decided = 1'b1;
                            n_verdict = ST_COUNT;
                        end else begin
                            n_frame_count = i_item.word[FI_W-1:0];
                            n_frame_index = '0;
                            if ({1'b0, i_item.packet_words} <
                                (26'(i_item.word[FI_W-1:0]) + 26'd2)) begin
                                n_decided = 1'b1;
                                n_verdict = ST_OVERRUN;
                            end else begin
                                n_phase = PH_TABLE;
                            end
                        end
                    end
                    PH_TABLE: begin
                        o_tbl.we      = 1'b1;
                        o_tbl.waddr   = r_frame_index;
                        o_tbl.wdata   = i_item.word;
                        // The first entry's check is kept for a packet that ends
                        // right after its table.
                        if (r_frame_index == '0) begin
                            n_first_bad = length_bad(i_item.word);
                        end
                        n_frame_index = r_frame_index + FI_W'(1);
                        if (n_frame_index >= r_frame_count) begin
                            n_phase       = PH_DATA;
                            n_frame_index = '0;
                            n_fso         = '0;
                            entered_data  = 1'b1;
                        end
                    end
                    PH_DATA: begin
                        if (r_fso == frame_off) begin
                            if (length_bad(i_cur_len)) begin
                                n_decided = 1'b1;
                                n_verdict = ST_LENGTH;
                            end else if (overrun) begin
                                n_decided = 1'b1;
                                n_verdict = ST_OVERRUN;
                            end else if (i_cur_len[1:0] != 2'b00) begin
                                n_fso    = r_fso + padded;
                                consumed = 1'b1;
                            end else if ((hdr_type == HDR_INNER_A) ||
                                         (hdr_type == HDR_INNER_B)) begin
                                n_inner   = i_item.word[TRIG_W-1:0];
                                n_decided = 1'b1;
                                n_verdict = ST_FOUND;
                            end else begin
                                if (hdr_type == HDR_OUTER) begin
                                    n_outer_seen = 1'b1;
                                    n_outer      = i_item.word[TRIG_W-1:0];
                                end
                                n_fso    = r_fso + i_cur_len[FSO_W-1:0];
                                consumed = 1'b1;
                            end
                            if (consumed) begin
                                n_frame_index = r_frame_index + FI_W'(1);
                                if (n_frame_index >= r_frame_count) begin
                                    n_decided = 1'b1;
                                    n_verdict = ST_NONE;
                                end
                            end
                        end
                    end
                endcase
            end

            if (r_word_index != '1) begin
                n_word_index = r_word_index + WI_W'(1);
            end

            if (i_item.last) begin
                // The pending frame is the first entry when this word ended the table, else the current
                // entry, or the next one when this word closed a frame.
                if (entered_data) begin
                    len_bad_last = n_first_bad;
                end else if (n_frame_index == r_frame_index) begin
                    len_bad_last = length_bad(i_cur_len);
                end else begin
                    len_bad_last = length_bad(i_nxt_len);
                end
                fin = n_verdict;
                if (!n_decided) begin
                    unique case (n_phase)
                        PH_HEADER, PH_COUNT: fin = ST_SIZE;
                        PH_TABLE:            fin = ST_OVERRUN;
                        PH_DATA:             fin = len_bad_last ? ST_LENGTH : ST_OVERRUN;
                    endcase
                end
                o_res_valid         = 1'b1;
                o_res.status        = fin;
                o_res.inner_trigger = (fin == ST_FOUND) ? n_inner : '0;
                o_res.outer_seen    = n_outer_seen;
                o_res.outer_trigger = n_outer;

                n_phase       = PH_HEADER;
                n_decided     = 1'b0;
                n_verdict     = ST_NONE;
                n_word_index  = '0;
                n_frame_count = '0;
                n_frame_index = '0;
                n_fso         = '0;
                n_inner       = '0;
                n_outer_seen  = 1'b0;
                n_outer       = '0;
            end
        end

        o_tbl.raddr_cur = n_frame_index;
        o_tbl.raddr_nxt = n_frame_index + FI_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HEADER;
            r_decided     <= 1'b0;
            r_verdict     <= ST_NONE;
            r_word_index  <= '0;
            r_frame_count <= '0;
            r_frame_index <= '0;
            r_fso         <= '0;
            r_inner       <= '0;
            r_outer_seen  <= 1'b0;
            r_outer       <= '0;
        end else begin
            r_phase       <= n_phase;
            r_decided     <= n_decided;
            r_verdict     <= n_verdict;
            r_word_index  <= n_word_index;
            r_frame_count <= n_frame_count;
            r_frame_index <= n_frame_index;
            r_fso         <= n_fso;
            r_inner       <= n_inner;
            r_outer_seen  <= n_outer_seen;
            r_outer       <= n_outer;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first_bad <= n_first_bad;
    end

    assign o_stat.phase       = r_phase;
    assign o_stat.decided     = r_decided;
    assign o_stat.frame_index = r_frame_index;
    assign o_stat.frame_count = r_frame_count;

endmodule

// ===== src/packet_frame_trigger_extractor.sv =====
// Result: a last word's result goes to the result register, which offers it.
// Throughput: one packet word per cycle unless a last word waits for result room;
// the parser handles a word in a single pass, looking up frame lengths in a length
// table RAM with two registered read ports. Reset: synchronous, active low; it empties
// both pipeline registers and returns the parser to the header phase (table kept).
`include "assert_macros.svh"

module packet_frame_trigger_extractor #(
    parameter int MAX_FRAMES       = pfte_pkg::MAX_FRAMES_DEF,
    parameter int MAX_PACKET_WORDS = pfte_pkg::MAX_PACKET_WORDS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pfte_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pfte_pkg::t_out_item o_out_item
);
    import pfte_pkg::*;

    localparam int TBL_AW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int TBL_DEPTH = 2 ** TBL_AW;

    logic        in_q_valid;
    t_in_item    in_q;
    logic        step;
    logic        out_free;
    logic        res_valid;
    t_out_item   res;
    t_tbl_req    tbl;
    t_parse_stat stat;
    logic [WORD_W-1:0] cur_len;
    logic [WORD_W-1:0] nxt_len;

    // A last word waits in the input register until the result register has room.
    assign step = in_q_valid && (!in_q.last || out_free);

    pfte_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .o_valid (in_q_valid),
        .o_item  (in_q),
        .i_pop   (step)
    );

    pfte_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TBL_DEPTH)
    ) u_len_table (
        .i_clk     (i_clk),
        .i_we      (tbl.we),
        .i_waddr   (tbl.waddr[TBL_AW-1:0]),
        .i_wdata   (tbl.wdata),
        .i_raddr_a (tbl.raddr_cur[TBL_AW-1:0]),
        .o_rdata_a (cur_len),
        .i_raddr_b (tbl.raddr_nxt[TBL_AW-1:0]),
        .o_rdata_b (nxt_len)
    );

    pfte_parser #(
        .MAX_FRAMES       (MAX_FRAMES),
        .MAX_PACKET_WORDS (MAX_PACKET_WORDS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (in_q),
        .i_cur_len   (cur_len),
        .i_nxt_len   (nxt_len),
        .o_tbl       (tbl),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_stat      (stat)
    );

    pfte_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

    `PFTE_ASSERT(a_res_has_room, i_clk, i_rst_n, !res_valid || out_free)
    `PFTE_ASSERT_NEXT(a_clear_after_res, i_clk, i_rst_n, res_valid, (stat.phase == PH_HEADER) && !stat.decided && (stat.frame_index == '0))
    `PFTE_ASSERT(a_walk_in_table, i_clk, i_rst_n, !((stat.phase == PH_DATA) && !stat.decided) || (stat.frame_index < stat.frame_count))

endmodule

// ===== tb/packet_frame_trigger_extractor_tb.sv =====
`timescale 1ns / 1ps

module packet_frame_trigger_extractor_tb;
    import pfte_pkg::*;

    localparam int RANDOM_ITEMS = 1650;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item want;
    } t_row;

    localparam t_out_item NO_RESULT = '0;

    // Directed packets, one row per word. Results are typed in on the last word.
    localparam t_row DIRECTED [26] = '{
        '{{MAGIC_BE, 25'd0, 1'b1}, 1'b1, {ST_SIZE, 16'h0000, 1'b0, 16'h0000}},
        '{{32'hFFFFFFFF, 25'h1FFFFFF, 1'b1}, 1'b1, {ST_SIZE, 16'h0000, 1'b0, 16'h0000}},
        '{{32'h12345678, 25'd2, 1'b0}, 1'b0, NO_RESULT},
        '{{32'h00000000, 25'd2, 1'b1}, 1'b1, {ST_MAGIC, 16'h0000, 1'b0, 16'h0000}},
        '{{MAGIC_LE, 25'd2, 1'b1}, 1'b1, {ST_SIZE, 16'h0000, 1'b0, 16'h0000}},
        '{{MAGIC_BE, 25'd3, 1'b0}, 1'b0, NO_RESULT},
        '{{32'd0, 25'd3, 1'b1}, 1'b1, {ST_COUNT, 16'h0000, 1'b0, 16'h0000}},
        '{{MAGIC_LE, 25'd300, 1'b0}, 1'b0, NO_RESULT},
        '{{32'd251, 25'd300, 1'b1}, 1'b1, {ST_COUNT, 16'h0000, 1'b0, 16'h0000}},
        '{{MAGIC_BE, 25'd4, 1'b0}, 1'b0, NO_RESULT},
        '{{32'd3, 25'd4, 1'b1}, 1'b1, {ST_OVERRUN, 16'h0000, 1'b0, 16'h0000}},
        '{{MAGIC_BE, 25'd5, 1'b0}, 1'b0, NO_RESULT},
        '{{32'd1, 25'd5, 1'b0}, 1'b0, NO_RESULT},
        '{{32'd4, 25'd5, 1'b0}, 1'b0, NO_RESULT},
        '{{32'h5800ABCD, 25'd5, 1'b1}, 1'b1, {ST_FOUND, 16'hABCD, 1'b0, 16'h0000}},
        '{{MAGIC_LE, 25'd5, 1'b0}, 1'b0, NO_RESULT},
        '{{32'd1, 25'd5, 1'b0}, 1'b0, NO_RESULT},
        '{{32'h80000000, 25'd5, 1'b0}, 1'b0, NO_RESULT},
        '{{32'h12345678, 25'd5, 1'b1}, 1'b1, {ST_LENGTH, 16'h0000, 1'b0, 16'h0000}},
        '{{MAGIC_BE, 25'd7, 1'b0}, 1'b0, NO_RESULT},
        '{{32'd2, 25'd7, 1'b0}, 1'b0, NO_RESULT},
        '{{32'd4, 25'd7, 1'b0}, 1'b0, NO_RESULT},
        '{{32'd6, 25'd7, 1'b0}, 1'b0, NO_RESULT},
        '{{32'h70001234, 25'd7, 1'b0}, 1'b0, NO_RESULT},
        '{{32'h00000000, 25'd7, 1'b0}, 1'b0, NO_RESULT},
        '{{32'h00000000, 25'd7, 1'b1}, 1'b1, {ST_NONE, 16'h0000, 1'b1, 16'h1234}}
    };

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    packet_frame_trigger_extractor dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Parser state as the block should hold it.
    t_phase      pr_phase;
    logic [24:0] pr_word_idx;
    logic [7:0]  pr_nframes;
    logic [31:0] pr_lengths [256];
    logic [7:0]  pr_frame;
    logic [26:0] pr_frame_off;
    t_status     pr_status;
    logic [15:0] pr_inner;
    logic        pr_outer_seen;
    logic [15:0] pr_outer;
    logic        pr_done;

    t_out_item pending_results [$];
    t_in_item  next_packet [$];
    int        failures        = 0;
    int        items_sent      = 0;
    int        packets_checked = 0;
    int        cycle_count     = 0;

    function automatic void start_new_packet();
        pr_phase      = PH_HEADER;
        pr_word_idx   = '0;
        pr_nframes    = '0;
        pr_frame      = '0;
        pr_frame_off  = '0;
        pr_status     = ST_NONE;
        pr_inner      = '0;
        pr_outer_seen = 1'b0;
        pr_outer      = '0;
        pr_done       = 1'b0;
    endfunction

    function automatic void settle(input t_status s);
        pr_status = s;
        pr_done   = 1'b1;
    endfunction

    function automatic bit bad_length(input logic [31:0] len);
        return len == 32'd0 || len[31];
    endfunction

    function automatic void walk_frame(input logic [31:0] w, input logic [24:0] pw);
        longint      at;
        longint      data_bytes;
        logic [31:0] flen;
        logic [3:0]  hdr;
        at         = 4 * (longint'(pr_word_idx) - 2 - longint'(pr_nframes));
        data_bytes = 4 * longint'(pw) - 8 - 4 * longint'(pr_nframes);
        if (longint'(pr_frame_off) != at) begin
            return;
        end
        flen = pr_lengths[pr_frame];
        if (bad_length(flen)) begin
            settle(ST_LENGTH);
            return;
        end
        if (longint'(pr_frame_off) + longint'(flen) > data_bytes) begin
            settle(ST_OVERRUN);
            return;
        end
        if (flen[1:0] != 2'b00) begin
            // Odd-sized frames are stepped over, rounded up to whole words.
            pr_frame_off = pr_frame_off + 27'({flen[31:2], 2'b00} + 32'd4);
        end else begin
            hdr = w[30:27];
            if (hdr == HDR_INNER_A || hdr == HDR_INNER_B) begin
                pr_inner = w[15:0];
                settle(ST_FOUND);
                return;
            end
            if (hdr == HDR_OUTER) begin
                pr_outer_seen = 1'b1;
                pr_outer      = w[15:0];
            end
            pr_frame_off = pr_frame_off + 27'(flen);
        end
        pr_frame = pr_frame + 8'd1;
        if (pr_frame >= pr_nframes) begin
            settle(ST_NONE);
        end
    endfunction

    function automatic bit parse_word(input t_in_item it, output t_out_item res);
        res = '0;
        if (!pr_done) begin
            case (pr_phase)
                PH_HEADER: begin
                    if (it.packet_words < 2 || it.packet_words > MAX_PACKET_WORDS_DEF) begin
                        settle(ST_SIZE);
                    end else if (it.word != MAGIC_BE && it.word != MAGIC_LE) begin
                        settle(ST_MAGIC);
                    end else begin
                        pr_phase = PH_COUNT;
                    end
                end
                PH_COUNT: begin
                    if (it.word < 1 || it.word > MAX_FRAMES_DEF) begin
                        settle(ST_COUNT);
                    end else begin
                        pr_nframes = it.word[7:0];
                        pr_frame   = '0;
                        if (32'(it.packet_words) < 32'd2 + it.word) begin
                            settle(ST_OVERRUN);
                        end else begin
                            pr_phase = PH_TABLE;
                        end
                    end
                end
                PH_TABLE: begin
                    pr_lengths[pr_frame] = it.word;
                    pr_frame = pr_frame + 8'd1;
                    if (pr_frame >= pr_nframes) begin
                        pr_phase     = PH_DATA;
                        pr_frame     = '0;
                        pr_frame_off = '0;
                    end
                end
                default: walk_frame(it.word, it.packet_words);
            endcase
        end
        if (pr_word_idx != '1) begin
            pr_word_idx = pr_word_idx + 25'd1;
        end
        if (!it.last) begin
            return 1'b0;
        end
        // The last word forces a verdict on a parse that is still open.
        if (!pr_done) begin
            if (pr_phase == PH_HEADER || pr_phase == PH_COUNT) begin
                settle(ST_SIZE);
            end else if (pr_phase == PH_TABLE) begin
                settle(ST_OVERRUN);
            end else if (bad_length(pr_lengths[pr_frame])) begin
                settle(ST_LENGTH);
            end else begin
                settle(ST_OVERRUN);
            end
        end
        res.status        = pr_status;
        res.inner_trigger = (pr_status == ST_FOUND) ? pr_inner : 16'h0000;
        res.outer_seen    = pr_outer_seen;
        res.outer_trigger = pr_outer;
        start_new_packet();
        return 1'b1;
    endfunction

    function automatic logic [31:0] frame_header();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(7))
            0, 1:    w[30:27] = HDR_INNER_A;
            2:       w[30:27] = HDR_INNER_B;
            3, 4:    w[30:27] = HDR_OUTER;
            default: ;
        endcase
        return w;
    endfunction

    // Mostly well-formed packets with random content, some noise, and some
    // with a wrong declared size or a last word that comes early or late.
    task automatic build_packet();
        int unsigned     nf;
        int unsigned     r;
        int unsigned     k;
        int              total;
        logic [31:0]     words [$];
        logic [31:0]     lens [$];
        logic [31:0]     len;
        logic [24:0]     pw;
        next_packet.delete();
        r = $urandom_range(99);
        if (r < 12) begin
            pw = ($urandom_range(1) == 1) ? 25'($urandom) : 25'($urandom_range(0, 8));
            k  = $urandom_range(1, 5);
            for (int i = 0; i < k; i++) begin
                if (i == 0 && $urandom_range(1) == 1) begin
                    words.push_back($urandom_range(1) ? MAGIC_BE : MAGIC_LE);
                end else begin
                    words.push_back($urandom);
                end
            end
        end else begin
            nf = ($urandom_range(99) < 2) ? $urandom_range(1, MAX_FRAMES_DEF)
                                          : $urandom_range(1, 6);
            words.push_back($urandom_range(1) ? MAGIC_BE : MAGIC_LE);
            r = $urandom_range(99);
            if (r == 0) begin
                words.push_back(32'd0);
            end else if (r == 1) begin
                words.push_back(32'(MAX_FRAMES_DEF + 1));
            end else if (r == 2) begin
                words.push_back($urandom);
            end else begin
                words.push_back(32'(nf));
            end
            for (int i = 0; i < nf; i++) begin
                r = $urandom_range(99);
                if (r < 70) begin
                    len = 32'(4 * $urandom_range(1, 4));
                end else if (r < 85) begin
                    len = 32'($urandom_range(1, 15));
                end else if (r < 90) begin
                    len = 32'd0;
                end else if (r < 95) begin
                    len = {1'b1, 31'($urandom)};
                end else begin
                    len = $urandom;
                end
                lens.push_back(len);
                words.push_back(len);
            end
            foreach (lens[i]) begin
                k = (lens[i] <= 32'd64) ? (lens[i] + 3) / 4 : 2;
                if (k == 0) begin
                    k = 1;
                end
                words.push_back(frame_header());
                for (int j = 1; j < k; j++) begin
                    words.push_back($urandom);
                end
            end
            total = words.size();
            if ($urandom_range(9) == 0) begin
                total = total + $urandom_range(0, 6) - 3;
            end
            pw = 25'(total);
        end
        r = $urandom_range(99);
        if (r >= 80 && r < 90) begin
            k = $urandom_range(1, words.size());
            while (words.size() > k) begin
                void'(words.pop_back());
            end
        end else if (r >= 90) begin
            k = $urandom_range(1, 4);
            for (int i = 0; i < k; i++) begin
                words.push_back($urandom);
            end
        end
        foreach (words[i]) begin
            next_packet.push_back({words[i], pw, 1'(i == words.size() - 1)});
        end
    endtask

    task automatic report_failure(input string what, input t_out_item want,
                                  input t_out_item got);
        failures++;
        if (failures <= 10) begin
            $display("%s: expected status %0d inner %h seen %b outer %h, got status %0d inner %h seen %b outer %h",
                     what, want.status, want.inner_trigger, want.outer_seen,
                     want.outer_trigger, got.status, got.inner_trigger, got.outer_seen,
                     got.outer_trigger);
        end
    endtask

    task automatic send_item(input t_in_item it, input bit typed, input t_out_item want);
        t_out_item predicted;
        bit        produced;
        while (!(items_sent >= 700 && items_sent < 1000) && $urandom_range(99) < 19) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        produced = parse_word(it, predicted);
        if (typed) begin
            pending_results.push_back(want);
        end else if (produced) begin
            pending_results.push_back(predicted);
        end
        items_sent++;
    endtask

    initial begin : stimulus
        int random_sent;
        random_sent = 0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item  <= '0;
        start_new_packet();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (DIRECTED[i]) begin
            send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);
        end
        while (random_sent < RANDOM_ITEMS) begin
            build_packet();
            foreach (next_packet[i]) begin
                send_item(next_packet[i], 1'b0, NO_RESULT);
            end
            random_sent += next_packet.size();
        end
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_failure("missing result", pending_results[0], 'x);
        end
        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Result side: random stalls, one quiet stretch, and one long hold-off so
    // that the block backs up and stops taking requests.
    initial begin : result_sink
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!held && packets_checked >= 20) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= (packets_checked >= 50 && packets_checked < 80)
                               || $urandom_range(99) >= 19;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            packets_checked++;
            if (pending_results.size() == 0) begin
                report_failure("unexpected result", 'x, o_out_item);
            end else begin
                want = pending_results.pop_front();
                if (o_out_item.status !== want.status
                        || o_out_item.inner_trigger !== want.inner_trigger
                        || o_out_item.outer_seen !== want.outer_seen
                        || o_out_item.outer_trigger !== want.outer_trigger) begin
                    report_failure("result mismatch", want, o_out_item);
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== packet_frame_trigger_extractor.f =====
+incdir+src
src/pfte_pkg.sv
src/pfte_ram.sv
src/pfte_in_stage.sv
src/pfte_out_stage.sv
src/pfte_parser.sv
src/packet_frame_trigger_extractor.sv
tb/packet_frame_trigger_extractor_tb.sv
